FILE: rtl/crsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc_pkg: shared types and constants of the clock replacement sector cache
// Request and response beat layouts, field widths and request codes.
// ----------------------------------------------------------------------------
package crsc_pkg;

  localparam int CACHE_ENTRIES_DEF = 64;
  localparam int SECTOR_W          = 32;
  localparam int SLOT_W            = 6;
  localparam int FUNC_W            = 2;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [SECTOR_W-1:0] sector;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic                fill_needed;
    logic                writeback;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } rsp_t;

endpackage

FILE: rtl/crsc_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc_tag_ram: sector tag store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crsc_tag_ram #(
  parameter int ENTRIES = crsc_pkg::CACHE_ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [IW-1:0]                 rd_addr,
  output logic [crsc_pkg::SECTOR_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [IW-1:0]                 wr_addr,
  input  logic [crsc_pkg::SECTOR_W-1:0] wr_data
);

  logic [crsc_pkg::SECTOR_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/crsc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsc_seq: lookup, clock sweep and flush sequencer
// Walks the slots one at a time with a single shared tag comparator and
// keeps the per-slot valid, dirty and reference bits plus the clock hand.
// ----------------------------------------------------------------------------
module crsc_seq #(
  parameter int ENTRIES = crsc_pkg::CACHE_ENTRIES_DEF,
  parameter int IW      = $clog2(ENTRIES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  crsc_pkg::req_t                req,
  output logic                          res_valid,
  input  logic                          res_ready,
  output crsc_pkg::rsp_t                res,
  output logic                          rd_en,
  output logic [IW-1:0]                 rd_addr,
  input  logic [crsc_pkg::SECTOR_W-1:0] rd_data,
  output logic                          wr_en,
  output logic [IW-1:0]                 wr_addr,
  output logic [crsc_pkg::SECTOR_W-1:0] wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_SWEEP,
    S_FILL,
    S_FL_CHK,
    S_FL_TAG,
    S_EMIT
  } state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  state_t                        state;
  state_t                        ret;
  logic [ENTRIES-1:0]            valid;
  logic [ENTRIES-1:0]            dirty;
  logic [ENTRIES-1:0]            refd;
  logic [IW-1:0]                 hand;
  logic [IW-1:0]                 idx;
  logic [crsc_pkg::FUNC_W-1:0]   func;
  logic [crsc_pkg::SECTOR_W-1:0] sector;
  logic                          victim_wb;
  logic                          fl_last;

  logic [IW-1:0]      idx_inc;
  logic               tag_match;
  logic               more_dirty;
  logic [ENTRIES-1:0] vd;

  assign idx_inc   = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign tag_match = (rd_data == sector);
  assign vd        = valid & dirty;

  // Any valid dirty slot above the current one.
  always_comb begin
    more_dirty = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (j > int'(idx) && vd[j]) begin
        more_dirty = 1'b1;
      end
    end
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    rd_en = 1'b0;
    case (state)
      S_LK_RD:  rd_en = valid[idx];
      S_SWEEP:  rd_en = valid[idx] && !refd[idx] && dirty[idx];
      S_FL_CHK: rd_en = vd[idx];
      default:  rd_en = 1'b0;
    endcase
  end

  assign rd_addr = idx;
  assign wr_en   = (state == S_FILL);
  assign wr_addr = idx;
  assign wr_data = sector;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      valid     <= '0;
      dirty     <= '0;
      refd      <= '0;
      hand      <= '0;
      idx       <= '0;
      func      <= '0;
      sector    <= '0;
      victim_wb <= 1'b0;
      fl_last   <= 1'b0;
      res       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            func   <= req.func;
            sector <= req.sector;
            idx    <= '0;
            case (req.func)
              crsc_pkg::FUNC_READ,
              crsc_pkg::FUNC_WRITE: state <= S_LK_RD;
              crsc_pkg::FUNC_FLUSH: begin
                if (vd == '0) begin
                  res.hit              <= 1'b0;
                  res.slot             <= '0;
                  res.fill_needed      <= 1'b0;
                  res.writeback        <= 1'b0;
                  res.writeback_sector <= '0;
                  res.last             <= 1'b1;
                  ret                  <= S_IDLE;
                  state                <= S_EMIT;
                end else begin
                  state <= S_FL_CHK;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_LK_RD: begin
          if (valid[idx]) begin
            state <= S_LK_CMP;
          end else if (idx == LAST_IDX) begin
            idx   <= hand;
            state <= S_SWEEP;
          end else begin
            idx <= idx_inc;
          end
        end

        S_LK_CMP: begin
          if (tag_match) begin
            refd[idx] <= 1'b1;
            if (func == crsc_pkg::FUNC_WRITE) begin
              dirty[idx] <= 1'b1;
            end
            res.hit              <= 1'b1;
            res.slot             <= crsc_pkg::SLOT_W'(idx);
            res.fill_needed      <= 1'b0;
            res.writeback        <= 1'b0;
            res.writeback_sector <= '0;
            res.last             <= 1'b1;
            ret                  <= S_IDLE;
            state                <= S_EMIT;
          end else if (idx == LAST_IDX) begin
            idx   <= hand;
            state <= S_SWEEP;
          end else begin
            idx   <= idx_inc;
            state <= S_LK_RD;
          end
        end

        // Give referenced slots a second chance; stop on an invalid or
        // unreferenced one.
        S_SWEEP: begin
          if (!valid[idx] || !refd[idx]) begin
            victim_wb <= valid[idx] && dirty[idx];
            hand      <= idx_inc;
            state     <= S_FILL;
          end else begin
            refd[idx] <= 1'b0;
            idx       <= idx_inc;
          end
        end

        S_FILL: begin
          valid[idx]           <= 1'b1;
          refd[idx]            <= 1'b1;
          dirty[idx]           <= (func == crsc_pkg::FUNC_WRITE);
          res.hit              <= 1'b0;
          res.slot             <= crsc_pkg::SLOT_W'(idx);
          res.fill_needed      <= 1'b1;
          res.writeback        <= victim_wb;
          res.writeback_sector <= victim_wb ? rd_data : '0;
          res.last             <= 1'b1;
          ret                  <= S_IDLE;
          state                <= S_EMIT;
        end

        S_FL_CHK: begin
          if (vd[idx]) begin
            fl_last <= !more_dirty;
            state   <= S_FL_TAG;
          end else if (idx == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end

        S_FL_TAG: begin
          dirty[idx]           <= 1'b0;
          res.hit              <= 1'b0;
          res.slot             <= crsc_pkg::SLOT_W'(idx);
          res.fill_needed      <= 1'b0;
          res.writeback        <= 1'b1;
          res.writeback_sector <= rd_data;
          res.last             <= fl_last;
          if (fl_last) begin
            ret <= S_IDLE;
          end else begin
            idx <= idx_inc;
            ret <= S_FL_CHK;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (res_ready) begin
            state <= ret;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/clock_replacement_sector_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_sector_cache: second-chance write-back sector cache
// Tag and policy controller of a fully associative sector cache with a
// persistent clock hand, dirty write-back reporting and flush-all.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              beat type
//   --------  ----------  ---------------------  ----------------
//   req       in          req_valid / req_ready  crsc_pkg::req_t
//   rsp       out         rsp_valid / rsp_ready  crsc_pkg::rsp_t
//
// Operation: a read or write walks the tag store one slot at a time through a
// single comparator, reading and then comparing each valid slot and skipping
// each invalid one. A miss adds the clock sweep and the fill. A flush walks
// the slots and reports each valid dirty one for write-back.
// Each result beat passes through the output register on its way to rsp.
// Reset (rst, synchronous) clears every valid, dirty and reference bit and
// the hand at once; no clearing pass is needed. A stalled rsp holds its beat
// in the output register while the sequencer finishes the next beat or
// accepts the next request.
// ----------------------------------------------------------------------------
module clock_replacement_sector_cache #(
  parameter int CACHE_ENTRIES = crsc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  crsc_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output crsc_pkg::rsp_t rsp
);

  localparam int IW = $clog2(CACHE_ENTRIES);

  logic                          res_valid;
  logic                          res_ready;
  crsc_pkg::rsp_t                res;
  logic                          rd_en;
  logic [IW-1:0]                 rd_addr;
  logic [crsc_pkg::SECTOR_W-1:0] rd_data;
  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  logic [crsc_pkg::SECTOR_W-1:0] wr_data;

  crsc_tag_ram #(
    .ENTRIES (CACHE_ENTRIES),
    .IW      (IW)
  ) u_tag_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  crsc_seq #(
    .ENTRIES (CACHE_ENTRIES),
    .IW      (IW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Output register: take a new beat whenever the slot is empty or drains.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp <= res;
    end
  end

endmodule
